// ===== sv/ack_retry_controller_unit_defines.svh =====
// Assertion macros shared by the retry controller RTL.
`ifndef ACK_RETRY_CONTROLLER_UNIT_DEFINES_SVH
`define ACK_RETRY_CONTROLLER_UNIT_DEFINES_SVH

// Check that is masked while reset is high.
`define ARC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define ARC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/arc_pkg.sv =====
`default_nettype none
package arc_pkg;

  // Input item modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_POLL   = 2'd1;
  localparam logic [1:0] MODE_ACK    = 2'd2;
  localparam logic [1:0] MODE_CANCEL = 2'd3;

  // Poll result actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_RETRY  = 2'd2;
  localparam logic [1:0] ACT_FAILED = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 8'd1;

  // Register reset values
  localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd3;
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        accepted;
    logic        busy_res;
    logic [31:0] current_sequence;
    logic [7:0]  attempt_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_attempts;
    logic [31:0] retry_interval;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/arc_cfg.sv =====
`default_nettype none
module arc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data,
  output arc_pkg::cfg_t                     cfg
);

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts   <= arc_pkg::MAX_ATTEMPTS_RST;
      cfg.retry_interval <= arc_pkg::RETRY_INTERVAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arc_pkg::CFG_MAX_ATTEMPTS:   cfg.max_attempts   <= cfg_data[7:0];
        arc_pkg::CFG_RETRY_INTERVAL: cfg.retry_interval <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/arc_core.sv =====
`default_nettype none
`include "ack_retry_controller_unit_defines.svh"
module arc_core (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire arc_pkg::in_item_t item,
  input  wire arc_pkg::cfg_t  cfg,
  output arc_pkg::out_item_t res
);

  // Timer state
  logic        outstanding, outstanding_next;
  logic        first_send_due, first_send_due_next;
  logic [31:0] held_sequence, held_sequence_next;
  logic [31:0] last_attempt_time, last_attempt_time_next;
  logic [7:0]  attempts_made, attempts_made_next;

  logic [31:0] elapsed;
  logic [7:0]  limit;
  logic [7:0]  tries_inc;
  logic        interval_passed;
  logic        limit_reached;
  logic [1:0]  action;
  logic        accepted;
  logic        retry_fire;
  logic        fail_fire;

  // Elapsed time wraps modulo 2^32; zero limit acts as one
  assign elapsed         = item.now_ms - last_attempt_time;
  assign interval_passed = (elapsed >= cfg.retry_interval);
  assign limit           = (cfg.max_attempts == 8'd0) ? 8'd1 : cfg.max_attempts;
  assign limit_reached   = (attempts_made >= limit);
  assign tries_inc       = attempts_made + 8'd1;

  // Event decode
  always_comb begin
    outstanding_next       = outstanding;
    first_send_due_next    = first_send_due;
    held_sequence_next     = held_sequence;
    last_attempt_time_next = last_attempt_time;
    attempts_made_next     = attempts_made;
    action                 = arc_pkg::ACT_NONE;
    accepted               = 1'b0;
    unique case (item.mode)
      arc_pkg::MODE_START: begin
        if (!outstanding) begin
          outstanding_next       = 1'b1;
          first_send_due_next    = 1'b1;
          held_sequence_next     = item.seq_number;
          last_attempt_time_next = item.now_ms;
          attempts_made_next     = 8'd0;
          accepted               = 1'b1;
        end
      end
      arc_pkg::MODE_POLL: begin
        if (outstanding) begin
          if (first_send_due) begin
            first_send_due_next    = 1'b0;
            last_attempt_time_next = item.now_ms;
            attempts_made_next     = 8'd1;
            action                 = arc_pkg::ACT_SEND;
          end else if (interval_passed) begin
            if (limit_reached) begin
              outstanding_next = 1'b0;
              action           = arc_pkg::ACT_FAILED;
            end else begin
              attempts_made_next     = tries_inc;
              last_attempt_time_next = item.now_ms;
              action                 = arc_pkg::ACT_RETRY;
            end
          end
        end
      end
      arc_pkg::MODE_ACK: begin
        if (outstanding && !first_send_due && (item.seq_number == held_sequence)) begin
          outstanding_next    = 1'b0;
          first_send_due_next = 1'b0;
          accepted            = 1'b1;
        end
      end
      arc_pkg::MODE_CANCEL: begin
        outstanding_next    = 1'b0;
        first_send_due_next = 1'b0;
      end
    endcase
  end

  // State update on each transaction leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding       <= 1'b0;
      first_send_due    <= 1'b0;
      held_sequence     <= '0;
      last_attempt_time <= '0;
      attempts_made     <= '0;
    end else if (fire) begin
      outstanding       <= outstanding_next;
      first_send_due    <= first_send_due_next;
      held_sequence     <= held_sequence_next;
      last_attempt_time <= last_attempt_time_next;
      attempts_made     <= attempts_made_next;
    end
  end

  assign res.action           = action;
  assign res.accepted         = accepted;
  assign res.busy_res         = outstanding_next;
  assign res.current_sequence = held_sequence_next;
  assign res.attempt_count    = attempts_made_next;

  assign retry_fire = fire && (action == arc_pkg::ACT_RETRY);
  assign fail_fire  = fire && (action == arc_pkg::ACT_FAILED);

  `ARC_CHECK_ALWAYS(a_send_due_armed, first_send_due |-> outstanding, "send due while idle")
  `ARC_CHECK(a_retry_counts, retry_fire |=> attempts_made == $past(tries_inc), "retry not counted")
  `ARC_CHECK(a_failed_disarms, fail_fire |=> !outstanding, "failure left block armed")

endmodule
`default_nettype wire

// ===== sv/ack_retry_controller_unit.sv =====
`default_nettype none
`include "ack_retry_controller_unit_defines.svh"
// Stop-and-wait retransmission timer for one outstanding message.
// Input channel (in_valid/in_stall/in_data): start, poll, acknowledge and
// cancel events with the current millisecond time and a sequence number.
// Output channel (out_valid/out_stall/out_data): one result per event with
// the poll action, accept flag, busy flag, held sequence and attempt count.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// attempt limit, index 1 the retry interval; other indexes are ignored.
// cfg_ready is always high; write only while no event is in flight.
// An accepted event passes through the input register, then the result
// register. Throughput: one event per cycle while the result is not stalled,
// set by the combinational decision logic between the two registers.
// A stalled result holds in the output register; the input register keeps
// accepting until it holds an event that cannot move, then in_stall rises.
// Reset clears the timer state and restores the limit (3) and the
// retry interval (1000 ms); both channels come out of reset empty.
module ack_retry_controller_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire arc_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output arc_pkg::out_item_t                out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data
);

  arc_pkg::in_item_t  in_reg;
  logic               in_reg_valid;
  arc_pkg::out_item_t res;
  arc_pkg::cfg_t      cfg;
  logic               out_free;
  logic               out_held;
  logic               fire;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign out_held  = out_valid && out_stall;
  assign fire      = in_reg_valid && out_free;
  assign in_stall  = in_reg_valid && !out_free;

  arc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg <= '0;
    end else if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  `ARC_CHECK(a_fire_gives_result, fire |=> out_valid, "transaction lost between stages")
  `ARC_CHECK(a_stall_blocked, in_stall |-> out_valid && out_stall, "stall without back-pressure")
  `ARC_CHECK(a_out_held, out_held |=> out_valid && $stable(out_data), "stalled result changed")

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes outside the register list; writes to them must be dropped
  localparam logic [arc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd2;
  localparam logic [arc_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  arc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  arc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ack_retry_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Timer mirror: registers plus message state
  logic [7:0]  lim_reg = arc_pkg::MAX_ATTEMPTS_RST;
  logic [31:0] ivl_reg = arc_pkg::RETRY_INTERVAL_RST;
  logic        tm_armed = 1'b0;
  logic        tm_send_due = 1'b0;
  logic [31:0] tm_seq = '0;
  logic [31:0] tm_stamp = '0;
  logic [7:0]  tm_tries = '0;

  arc_pkg::out_item_t predicted_status_q[$];
  int err_count = 0;
  int items_sent = 0;
  int hold_cnt = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  arc_pkg::out_item_t want;

  // Apply one event to the mirror and return the status it should report
  function automatic arc_pkg::out_item_t advance_timer(arc_pkg::in_item_t ev);
    arc_pkg::out_item_t r;
    logic [7:0] lim;
    logic [31:0] elapsed;
    r = '0;
    lim = (lim_reg == 8'd0) ? 8'd1 : lim_reg;
    elapsed = ev.now_ms - tm_stamp;
    case (ev.mode)
      arc_pkg::MODE_START: begin
        if (!tm_armed) begin
          tm_armed = 1'b1;
          tm_send_due = 1'b1;
          tm_seq = ev.seq_number;
          tm_stamp = ev.now_ms;
          tm_tries = 8'd0;
          r.accepted = 1'b1;
        end
      end
      arc_pkg::MODE_POLL: begin
        if (tm_armed) begin
          if (tm_send_due) begin
            tm_send_due = 1'b0;
            tm_stamp = ev.now_ms;
            tm_tries = 8'd1;
            r.action = arc_pkg::ACT_SEND;
          end else if (elapsed >= ivl_reg) begin
            if (tm_tries >= lim) begin
              tm_armed = 1'b0;
              r.action = arc_pkg::ACT_FAILED;
            end else begin
              tm_tries = tm_tries + 8'd1;
              tm_stamp = ev.now_ms;
              r.action = arc_pkg::ACT_RETRY;
            end
          end
        end
      end
      arc_pkg::MODE_ACK: begin
        if (tm_armed && !tm_send_due && ev.seq_number == tm_seq) begin
          tm_armed = 1'b0;
          r.accepted = 1'b1;
        end
      end
      default: begin
        tm_armed = 1'b0;
        tm_send_due = 1'b0;
      end
    endcase
    r.busy_res = tm_armed;
    r.current_sequence = tm_seq;
    r.attempt_count = tm_tries;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    err_count++;
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
  endtask

  // Result side: check each transaction, then pick a stall for the next one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_status_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.current_sequence, '0);
      end else begin
        want = predicted_status_q.pop_front();
        if (out_data.action !== want.action)
          report_mismatch("action", 32'(out_data.action), 32'(want.action));
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", 32'(out_data.accepted), 32'(want.accepted));
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(out_data.busy_res), 32'(want.busy_res));
        if (out_data.current_sequence !== want.current_sequence)
          report_mismatch("current_sequence", out_data.current_sequence,
                          want.current_sequence);
        if (out_data.attempt_count !== want.attempt_count)
          report_mismatch("attempt_count", 32'(out_data.attempt_count),
                          32'(want.attempt_count));
      end
      if ($urandom_range(0, 59) == 0) out_burst = !out_burst;
      hold_cnt = out_burst ? 0 : $urandom_range(0, 7);
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end
    out_stall <= (hold_cnt != 0);
  end

  // Send one event; predict its status once the input register accepts it
  task automatic send_event(logic [1:0] mode, logic [31:0] now, logic [31:0] seq);
    arc_pkg::in_item_t item;
    int gap;
    item.mode = mode;
    item.now_ms = now;
    item.seq_number = seq;
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predicted_status_q.push_back(advance_timer(item));
    items_sent++;
  endtask

  // Let every pending result come out before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write, then cfg_valid drops so back-to-back writes never collide
  task automatic write_reg(logic [arc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      arc_pkg::CFG_MAX_ATTEMPTS: lim_reg = val[7:0];
      arc_pkg::CFG_RETRY_INTERVAL: ivl_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Poll, ack and cancel with nothing armed
  task automatic test_idle_events();
    send_event(arc_pkg::MODE_POLL, 32'h0, 32'h0);
    send_event(arc_pkg::MODE_ACK, 32'hFFFF_FFFF, 32'h0);
    send_event(arc_pkg::MODE_CANCEL, 32'h0, 32'hFFFF_FFFF);
  endtask

  // Arming at the top of the field ranges, refused start and acks, wrapped time
  task automatic test_arm_and_ack();
    send_event(arc_pkg::MODE_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(arc_pkg::MODE_START, 32'h0, 32'h0);
    send_event(arc_pkg::MODE_ACK, 32'h0, 32'hFFFF_FFFF);
    send_event(arc_pkg::MODE_POLL, 32'hFFFF_FFFF, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd998, 32'h0);
    send_event(arc_pkg::MODE_ACK, 32'h0, 32'h7FFF_FFFF);
    send_event(arc_pkg::MODE_ACK, 32'h0, 32'hFFFF_FFFF);
  endtask

  // Default limit of three attempts, then failure
  task automatic test_retry_to_failure();
    send_event(arc_pkg::MODE_START, 32'd5, 32'hA5A5_A5A5);
    send_event(arc_pkg::MODE_POLL, 32'd10, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd1010, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd2009, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd2010, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd3010, 32'h0);
  endtask

  // Cancel keeps the sequence and attempt count visible
  task automatic test_cancel();
    send_event(arc_pkg::MODE_START, 32'h8000_0000, 32'h5A5A_5A5A);
    send_event(arc_pkg::MODE_POLL, 32'h8000_0001, 32'h0);
    send_event(arc_pkg::MODE_CANCEL, 32'h0, 32'h0);
  endtask

  // Zero limit, zero interval, unused indexes, limit lowered mid-flight
  task automatic test_limit_change();
    drain();
    write_reg(CFG_IDX_UNUSED, 32'h0000_0007);
    write_reg(CFG_IDX_TOP, 32'hFFFF_FFFF);
    write_reg(arc_pkg::CFG_MAX_ATTEMPTS, 32'h0);
    write_reg(arc_pkg::CFG_RETRY_INTERVAL, 32'h0);
    send_event(arc_pkg::MODE_START, 32'd100, 32'h0F0F_0F0F);
    send_event(arc_pkg::MODE_POLL, 32'd100, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd100, 32'h0);
    drain();
    write_reg(arc_pkg::CFG_MAX_ATTEMPTS, 32'd5);
    write_reg(arc_pkg::CFG_RETRY_INTERVAL, 32'd10);
    send_event(arc_pkg::MODE_START, 32'd200, 32'h1234_5678);
    send_event(arc_pkg::MODE_POLL, 32'd200, 32'h0);
    send_event(arc_pkg::MODE_POLL, 32'd210, 32'h0);
    drain();
    write_reg(arc_pkg::CFG_MAX_ATTEMPTS, 32'd1);
    send_event(arc_pkg::MODE_POLL, 32'd220, 32'h0);
  endtask

  // One message lifetime: arm, send, polls around the interval, then close
  task automatic run_exchange();
    logic [31:0] seq;
    logic [31:0] now;
    logic [31:0] step;
    int lim;
    int polls;
    int i;
    seq = $urandom;
    now = $urandom;
    lim = (lim_reg == 8'd0) ? 1 : int'(lim_reg);
    if (tm_armed && $urandom_range(0, 3) != 0)
      send_event(arc_pkg::MODE_CANCEL, $urandom, $urandom);
    send_event(arc_pkg::MODE_START, now, seq);
    if ($urandom_range(0, 5) == 0) send_event(arc_pkg::MODE_ACK, $urandom, seq);
    if ($urandom_range(0, 7) == 0) send_event(arc_pkg::MODE_START, $urandom, $urandom);
    polls = $urandom_range(1, lim + 2);
    for (i = 0; i < polls; i++) begin
      case ($urandom_range(0, 5))
        0: step = ivl_reg - 32'd1;
        1: step = ivl_reg;
        2: step = ivl_reg + 32'd1;
        3: step = ivl_reg + 32'($urandom_range(0, 50));
        4: step = 32'($urandom_range(0, 20));
        default: step = $urandom;
      endcase
      if (i > 0) now = now + step;
      send_event(arc_pkg::MODE_POLL, now, $urandom);
      if ($urandom_range(0, 9) == 0)
        send_event(arc_pkg::MODE_ACK, $urandom, seq ^ (32'h1 << $urandom_range(0, 31)));
    end
    case ($urandom_range(0, 5))
      0, 1, 2: send_event(arc_pkg::MODE_ACK, $urandom, seq);
      3, 4: send_event(arc_pkg::MODE_CANCEL, $urandom, $urandom);
      default: ;
    endcase
  endtask

  task automatic send_noise();
    logic [31:0] seq;
    seq = ($urandom_range(0, 1) != 0) ? tm_seq : $urandom;
    send_event(2'($urandom_range(0, 3)), $urandom, seq);
  endtask

  // Random traffic under several register settings, extremes included
  task automatic test_random_traffic();
    int ph;
    int target;
    logic [7:0] lim;
    logic [31:0] ivl;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin lim = arc_pkg::MAX_ATTEMPTS_RST; ivl = arc_pkg::RETRY_INTERVAL_RST; end
        1: begin lim = 8'd0; ivl = 32'h0; end
        2: begin lim = 8'hFF; ivl = 32'hFFFF_FFFF; end
        3: begin lim = 8'd1; ivl = 32'd1; end
        4: begin lim = 8'($urandom_range(2, 8)); ivl = 32'($urandom_range(0, 2000)); end
        default: begin lim = 8'($urandom); ivl = $urandom; end
      endcase
      drain();
      write_reg(arc_pkg::CFG_MAX_ATTEMPTS, {24'($urandom), lim});
      write_reg(arc_pkg::CFG_RETRY_INTERVAL, ivl);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) != 0) run_exchange();
        else send_noise();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_arm_and_ack();
    test_retry_to_failure();
    test_cancel();
    test_limit_change();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (predicted_status_q.size() != 0)
      report_mismatch("results never delivered", 32'(predicted_status_q.size()), 32'd0);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== ack_retry_controller_unit.f =====
+incdir+sv
sv/arc_pkg.sv
sv/arc_cfg.sv
sv/arc_core.sv
sv/ack_retry_controller_unit.sv
bench/tb.sv
